/* design/md4_pkg.sv */
// Shared constants, types and helper functions of the MD4 hash unit.
// No dependencies; md4_ctrl, md4_dp and md4_hash_unit import this package.
`default_nettype none

package md4_pkg;

  localparam int MSG_WORDS = 16;
  localparam int ROUNDS    = 48;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] K_ROUND1 = 32'h00000000;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] PAD_LIMIT = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
  localparam logic [3:0] LAST_WORD_IDX = 4'(MSG_WORDS - 1);

  localparam logic [1:0] STAGE_F = 2'd0;
  localparam logic [1:0] STAGE_G = 2'd1;

  localparam logic [3:0] WORD_ORDER [ROUNDS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  typedef struct packed {
    logic       take;
    logic       append;
    logic       spill;
    logic       pad;
    logic       pad_zero;
    logic       load;
    logic       round;
    logic       fold;
    logic       emit;
    logic [5:0] rnd;
  } md4_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic pad_two;
  } md4_status_t;

  function automatic logic [4:0] rot_amount(input logic [1:0] stage, input logic [1:0] step);
    logic [4:0] s;
    case ({stage, step})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_const(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      STAGE_F: k = K_ROUND1;
      STAGE_G: k = K_ROUND2;
      default: k = K_ROUND3;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] byte_mask(input logic [2:0] cnt);
    logic [3:0] m;
    case (cnt)
      3'd0:    m = 4'b0000;
      3'd1:    m = 4'b0001;
      3'd2:    m = 4'b0011;
      3'd3:    m = 4'b0111;
      default: m = 4'b1111;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

`default_nettype wire

/* design/md4_msg_if.sv */
// Message channel of the MD4 hash unit: valid/ready plus one message word.
// No dependencies.
`default_nettype none

interface md4_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

`default_nettype wire

/* design/md4_digest_if.sv */
// Digest channel of the MD4 hash unit: valid/ready plus the four digest words.
// No dependencies.
`default_nettype none

interface md4_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

`default_nettype wire

/* design/md4_ctrl.sv */
// Sequencer of the MD4 hash unit: steps append, padding and compression.
// Depends on md4_pkg for the command and status structs.
`default_nettype none

module md4_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire md4_pkg::md4_status_t status,
  output md4_pkg::md4_cmd_t       cmd
);
  import md4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_LOAD, S_ROUND, S_FOLD, S_SPILL, S_PAD, S_PAD2, S_EMIT
  } state_t;

  typedef enum logic [1:0] {R_SPILL, R_PAD2, R_EMIT} after_t;

  state_t     state;
  after_t     after;
  logic [5:0] rnd;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd     = '0;
    cmd.rnd = rnd;
    case (state)
      S_IDLE:   cmd.take     = in_valid;
      S_APPEND: cmd.append   = 1'b1;
      S_LOAD:   cmd.load     = 1'b1;
      S_ROUND:  cmd.round    = 1'b1;
      S_FOLD:   cmd.fold     = 1'b1;
      S_SPILL:  cmd.spill    = 1'b1;
      S_PAD:    cmd.pad      = 1'b1;
      S_PAD2:   cmd.pad_zero = 1'b1;
      S_EMIT:   cmd.emit     = !out_valid || out_ready;
      default:  cmd.take     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after     <= R_EMIT;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.emit) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_APPEND;
        end
        S_APPEND: begin
          if (status.full) begin
            after <= R_SPILL;
            state <= S_LOAD;
          end else if (status.last) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd == LAST_ROUND) state <= S_FOLD;
          else rnd <= rnd + 6'd1;
        end
        S_FOLD: begin
          case (after)
            R_SPILL: state <= S_SPILL;
            R_PAD2:  state <= S_PAD2;
            default: state <= S_EMIT;
          endcase
        end
        S_SPILL: begin
          state <= status.last ? S_PAD : S_IDLE;
        end
        S_PAD: begin
          after <= status.pad_two ? R_PAD2 : R_EMIT;
          state <= S_LOAD;
        end
        S_PAD2: begin
          after <= R_EMIT;
          state <= S_LOAD;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/md4_dp.sv */
// Datapath of the MD4 hash unit: block buffer, byte counter, round unit,
// chaining and digest registers. Depends on md4_pkg.
`default_nettype none

module md4_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire md4_pkg::md4_cmd_t    cmd,
  output md4_pkg::md4_status_t      status,
  input  wire logic [31:0]          data_word,
  input  wire logic [2:0]           byte_count,
  input  wire logic                 last_word,
  output logic [31:0]               digest_a,
  output logic [31:0]               digest_b,
  output logic [31:0]               digest_c,
  output logic [31:0]               digest_d
);
  import md4_pkg::*;

  logic [31:0] msg      [MSG_WORDS];
  logic [31:0] msg_next [MSG_WORDS];

  logic [31:0] word;
  logic [2:0]  cnt;
  logic        last;
  logic [31:0] spill_data;
  logic [3:0]  spill_mask;

  logic [60:0] byte_total;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;

  logic [5:0]  pos;
  logic [3:0]  pw;
  logic [63:0] sh;
  logic [7:0]  mk;
  logic [6:0]  fill;
  logic [63:0] len;

  logic [1:0]  stage;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;

  assign pos  = byte_total[5:0];
  assign pw   = pos[5:2];
  assign sh   = {32'd0, word} << {pos[1:0], 3'b000};
  assign mk   = {4'd0, byte_mask(cnt)} << pos[1:0];
  assign fill = {1'b0, pos} + {4'd0, cnt};
  assign len  = {byte_total, 3'b000};

  assign status.full    = fill[6];
  assign status.last    = last;
  assign status.pad_two = (pos >= PAD_LIMIT);

  assign stage = cmd.rnd[5:4];

  always_comb begin
    case (stage)
      STAGE_F: f = (wb & wc) | (~wb & wd);
      STAGE_G: f = (wb & wc) | (wb & wd) | (wc & wd);
      default: f = wb ^ wc ^ wd;
    endcase
  end

  assign sum = wa + f + msg[WORD_ORDER[cmd.rnd]] + round_const(stage);
  assign rot = rotl32(sum, rot_amount(stage, cmd.rnd[1:0]));

  always_comb begin
    msg_next = msg;
    if (cmd.append) begin
      for (int j = 0; j < 4; j++) begin
        if (mk[j]) msg_next[pw][8*j +: 8] = sh[8*j +: 8];
        if (mk[4+j] && pw != LAST_WORD_IDX) msg_next[pw + 4'd1][8*j +: 8] = sh[32+8*j +: 8];
      end
    end
    if (cmd.spill) begin
      for (int j = 0; j < 4; j++) begin
        if (spill_mask[j]) msg_next[0][8*j +: 8] = spill_data[8*j +: 8];
      end
    end
    if (cmd.pad) begin
      for (int w = 0; w < MSG_WORDS; w++) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(w*4 + j) == pos) msg_next[w][8*j +: 8] = PAD_BYTE;
          else if (6'(w*4 + j) > pos) msg_next[w][8*j +: 8] = 8'd0;
        end
      end
      if (!status.pad_two) begin
        msg_next[MSG_WORDS-2] = len[31:0];
        msg_next[MSG_WORDS-1] = len[63:32];
      end
    end
    if (cmd.pad_zero) begin
      for (int w = 0; w < MSG_WORDS - 2; w++) msg_next[w] = 32'd0;
      msg_next[MSG_WORDS-2] = len[31:0];
      msg_next[MSG_WORDS-1] = len[63:32];
    end
  end

  always_ff @(posedge clk) begin
    msg <= msg_next;
    if (cmd.take) begin
      word <= data_word;
      cnt  <= (byte_count > 3'd4) ? 3'd4 : byte_count;
      last <= last_word;
    end
    if (cmd.append) begin
      spill_data <= sh[63:32];
      spill_mask <= mk[7:4];
    end
    if (cmd.load) begin
      wa <= chain_a;
      wb <= chain_b;
      wc <= chain_c;
      wd <= chain_d;
    end
    if (cmd.round) begin
      wa <= wd;
      wb <= rot;
      wc <= wb;
      wd <= wc;
    end
    if (cmd.emit) begin
      digest_a <= chain_a;
      digest_b <= chain_b;
      digest_c <= chain_c;
      digest_d <= chain_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_a    <= INIT_A;
      chain_b    <= INIT_B;
      chain_c    <= INIT_C;
      chain_d    <= INIT_D;
      byte_total <= '0;
    end else begin
      if (cmd.append) byte_total <= byte_total + {58'd0, cnt};
      if (cmd.fold) begin
        chain_a <= chain_a + wa;
        chain_b <= chain_b + wb;
        chain_c <= chain_c + wc;
        chain_d <= chain_d + wd;
      end
      if (cmd.emit) begin
        chain_a    <= INIT_A;
        chain_b    <= INIT_B;
        chain_c    <= INIT_C;
        chain_d    <= INIT_D;
        byte_total <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/md4_hash_unit.sv */
// MD4 digest engine (RFC 1320) over a stream of little-endian message words.
// Each accepted word is first taken and then has its bytes stored. Each
// filled 64-byte block then runs through the single round unit: a load step,
// 48 rounds at one round per cycle, a fold step into the chaining words, and
// a step to store bytes that ran past the block end. The final word adds a
// padding step and one compression, or two with an extra padding step when
// fewer than nine bytes remain in the block, and then an emit step that waits
// while an earlier digest has not been taken. The unit then starts a new
// message from the initial state.
// Depends on md4_pkg, md4_msg_if, md4_digest_if, md4_ctrl and md4_dp.
`default_nettype none

module md4_hash_unit (
  input  wire logic clk,
  input  wire logic rst,
  md4_msg_if.sink      message,
  md4_digest_if.source digest
);
  import md4_pkg::*;

  md4_cmd_t    cmd;
  md4_status_t status;

  md4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (message.valid),
    .in_ready  (message.ready),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .status    (status),
    .cmd       (cmd)
  );

  md4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .data_word  (message.data_word),
    .byte_count (message.byte_count),
    .last_word  (message.last_word),
    .digest_a   (digest.digest_a),
    .digest_b   (digest.digest_b),
    .digest_c   (digest.digest_c),
    .digest_d   (digest.digest_d)
  );

endmodule

`default_nettype wire

/* dv/md4_hash_unit_tb.sv */
// Self-checking testbench of md4_hash_unit: random and directed messages with a
// built-in MD4 digest predictor. Depends on md4_msg_if, md4_digest_if and the RTL.
`default_nettype none

module md4_hash_unit_tb;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  md4_msg_if    msg_bus ();
  md4_digest_if dig_bus ();

  md4_hash_unit uut (
    .clk(clk),
    .rst(rst),
    .message(msg_bus),
    .digest(dig_bus)
  );

  always #5 clk = ~clk;

  msg_word_t pending_words[$];
  digest_t   expected_digests[$];
  int        words_queued = 0;
  int        words_taken = 0;
  int        errors = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  logic      word_accepted = 1'b0;

  logic [31:0] chain[4];
  logic [7:0]  blk[64];
  logic [60:0] msg_bytes;

  function automatic void restart_hash();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    msg_bytes = '0;
  endfunction

  function automatic int rot_for(int stg, int step);
    case (stg * 4 + step)
      0: return 3;
      1: return 7;
      2: return 11;
      3: return 19;
      4: return 3;
      5: return 5;
      6: return 9;
      7: return 13;
      8: return 3;
      9: return 9;
      10: return 11;
      default: return 15;
    endcase
  endfunction

  function automatic void md4_compress();
    logic [31:0] m[16];
    logic [31:0] r[4];
    logic [31:0] x, y, z, f, k, sum;
    logic [3:0]  j, idx;
    int          t, stg, sh;
    for (int i = 0; i < 16; i++) m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    for (int i = 0; i < 4; i++) r[i] = chain[i];
    for (int i = 0; i < 48; i++) begin
      stg = i / 16;
      t = (4 - (i % 4)) % 4;
      x = r[(t + 1) % 4];
      y = r[(t + 2) % 4];
      z = r[(t + 3) % 4];
      j = 4'(i % 16);
      case (stg)
        0: begin
          f = (x & y) | (~x & z);
          k = 32'h00000000;
          idx = j;
        end
        1: begin
          f = (x & y) | (x & z) | (y & z);
          k = 32'h5A827999;
          idx = {j[1:0], j[3:2]};
        end
        default: begin
          f = x ^ y ^ z;
          k = 32'h6ED9EBA1;
          idx = {j[0], j[1], j[2], j[3]};
        end
      endcase
      sh = rot_for(stg, i % 4);
      sum = r[t] + f + m[idx] + k;
      r[t] = (sum << sh) | (sum >> (32 - sh));
    end
    for (int i = 0; i < 4; i++) chain[i] = chain[i] + r[i];
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int pos;
    pos = int'(msg_bytes[5:0]);
    blk[pos] = b;
    msg_bytes = msg_bytes + 61'd1;
    if (pos == 63) md4_compress();
  endfunction

  function automatic void absorb_word(logic [31:0] w, logic [2:0] c, logic l);
    int          n, pos;
    logic [63:0] bits;
    digest_t     dg;
    n = (c > 3'd4) ? 4 : int'(c);
    for (int i = 0; i < n; i++) take_byte(w[8*i +: 8]);
    if (l) begin
      pos = int'(msg_bytes[5:0]);
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        md4_compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      bits = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
      md4_compress();
      dg = {chain[0], chain[1], chain[2], chain[3]};
      expected_digests.push_back(dg);
      restart_hash();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void push_word(logic [31:0] w, logic [2:0] c, logic l);
    pending_words.push_back(msg_word_t'{data: w, cnt: c, last: l});
    words_queued++;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(8);
    if (r < 80) return $urandom_range(18, 12);
    if (r < 95) return $urandom_range(40, 19);
    return $urandom_range(140, 60);
  endfunction

  function automatic int add_message();
    int n;
    n = pick_length();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) push_word($urandom, 3'($urandom_range(7)), 1'b0);
      else push_word($urandom, 3'd4, 1'b0);
    end
    push_word($urandom, 3'($urandom_range(7)), 1'b1);
    return n + 1;
  endfunction

  task automatic drain();
    while (words_taken != words_queued || expected_digests.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    msg_word_t nxt;
    if (rst) begin
      msg_bus.valid <= 1'b0;
      dig_bus.ready <= 1'b0;
    end else begin
      if (!msg_bus.valid || word_accepted) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_words.pop_front();
          msg_bus.data_word  <= nxt.data;
          msg_bus.byte_count <= nxt.cnt;
          msg_bus.last_word  <= nxt.last;
          msg_bus.valid      <= 1'b1;
        end else begin
          msg_bus.valid <= 1'b0;
        end
      end
      dig_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    digest_t want;
    word_accepted = 1'b0;
    if (!rst) begin
      if (msg_bus.valid && msg_bus.ready) begin
        word_accepted = 1'b1;
        words_taken++;
        absorb_word(msg_bus.data_word, msg_bus.byte_count, msg_bus.last_word);
      end
      if (dig_bus.valid && dig_bus.ready) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: unexpected digest, expected none, actual %h %h %h %h", $time,
                   dig_bus.digest_a, dig_bus.digest_b, dig_bus.digest_c, dig_bus.digest_d);
          errors++;
        end else begin
          want = expected_digests.pop_front();
          check_field("digest_a", want.a, dig_bus.digest_a);
          check_field("digest_b", want.b, dig_bus.digest_b);
          check_field("digest_c", want.c, dig_bus.digest_c);
          check_field("digest_d", want.d, dig_bus.digest_d);
        end
      end
    end
  end

  initial begin
    int added;
    msg_bus.valid      = 1'b0;
    msg_bus.data_word  = '0;
    msg_bus.byte_count = '0;
    msg_bus.last_word  = 1'b0;
    dig_bus.ready      = 1'b0;
    restart_hash();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, short message, saturated counts, short non-final words
    push_word(32'h00000000, 3'd0, 1'b1);
    push_word(32'h00636261, 3'd3, 1'b1);
    push_word(32'hFFFFFFFF, 3'd5, 1'b1);
    push_word(32'h80000001, 3'd6, 1'b1);
    push_word(32'h12345678, 3'd7, 1'b1);
    push_word(32'hFFFFFFFF, 3'd0, 1'b0);
    push_word(32'hFFFFFF61, 3'd1, 1'b0);
    push_word(32'hAAAA5555, 3'd2, 1'b0);
    push_word(32'h5555AAAA, 3'd3, 1'b0);
    push_word(32'h00000000, 3'd4, 1'b0);
    push_word(32'hFFFFFF00, 3'd1, 1'b1);
    push_word(32'hFFFFFFFF, 3'd4, 1'b0);
    push_word(32'hFFFFFFFF, 3'd0, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 16 : 0;
      stall_pct = (ph == 2) ? 50 : (ph == 3) ? 16 : 0;
      added = 0;
      while (added < 385) added += add_message();
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
